@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int INDEX_W     = 6;
  localparam int PRIO_W      = 8;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // operation codes carried in the input tuser
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [INDEX_W-1:0] index;
  } entry_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic occupied;   // cell holds a live entry
    logic at_tail;    // cell is the first free position
    logic insert_en;  // an insert is applied this cycle
    logic shift_in;   // left neighbor moves in (insert point is further front)
    logic pull;       // right neighbor moves in (pop or gap close)
  } cell_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               dropped;
    logic               valid;
    logic [INDEX_W-1:0] index;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_priority_queue.sv @@
// each accepted input beat writes its result beat into the output register
// one beat per cycle when not stalled; all 64 cells update together in the accepting cycle
// the output register holds a result until taken, input stalls only while it is full
// reset (rst_n low, synchronous) empties the queue and clears the output valid;
// cell contents are left as they are and never read until written
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // entry_index[5:0], priority_req[13:6], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // out_index[5:0], out_valid[6], dropped[7],
                                  // queue_count[14:8], zero pad
);
  import spq_pkg::*;

  logic [COUNT_W-1:0]     count_r;
  logic [COUNT_W-1:0]     count_nxt;
  logic                   out_valid_r;
  result_t                res_r;
  result_t                res_nxt;

  entry_t                 new_entry;
  logic [1:0]             func;
  logic                   go;
  logic                   full;
  logic                   empty;
  logic                   found;
  logic                   ins_go;
  logic                   pop_go;
  logic                   rem_go;

  entry_t                 cell_entry [QUEUE_DEPTH];
  cell_ctl_t              cell_ctl   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] lower_v;
  logic [QUEUE_DEPTH-1:0] match_v;

  assign func            = in_tuser;
  assign new_entry.index = in_tdata[5:0];
  assign new_entry.prio  = in_tdata[13:6];

  assign in_tready = !out_valid_r || out_tready;
  assign go        = in_tvalid && in_tready;
  assign full      = (count_r == COUNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign found     = |match_v;

  assign ins_go = go && (func == FUNC_INSERT) && !full;
  assign pop_go = go && (func == FUNC_POP) && !empty;
  assign rem_go = go && (func == FUNC_REMOVE) && found;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t left_entry;
      entry_t right_entry;

      if (g == 0) begin : g_head
        assign left_entry         = new_entry;
        assign cell_ctl[g].shift_in = 1'b0;
      end else begin : g_body
        assign left_entry         = cell_entry[g-1];
        assign cell_ctl[g].shift_in = lower_v[g-1];
      end

      // last cell pulls in its own stale value; that slot is freed anyway
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign right_entry = cell_entry[g];
      end else begin : g_mid
        assign right_entry = cell_entry[g+1];
      end

      assign cell_ctl[g].occupied  = (COUNT_W'(g) < count_r);
      assign cell_ctl[g].at_tail   = (COUNT_W'(g) == count_r);
      assign cell_ctl[g].insert_en = ins_go;
      // every cell at or behind the first match closes the gap
      assign cell_ctl[g].pull      = pop_go || (rem_go && (|match_v[g:0]));

      spq_cell u_cell (
        .clk         (clk),
        .ctl         (cell_ctl[g]),
        .new_entry   (new_entry),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (cell_entry[g]),
        .lower       (lower_v[g]),
        .match       (match_v[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ins_go) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (pop_go || rem_go) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_comb begin
    res_nxt.index   = pop_go ? cell_entry[0].index : '0;
    res_nxt.valid   = pop_go || rem_go;
    res_nxt.dropped = (func == FUNC_INSERT) && full;
    res_nxt.count   = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        count_r <= count_nxt;
      end
      out_valid_r <= go || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (func == FUNC_INSERT) && full) |=> (res_r.dropped && (count_r == $past(count_r))))
    else $error("insert into full queue not dropped");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_go |=> (res_r.valid && (count_r == $past(count_r) - COUNT_W'(1))))
    else $error("pop did not shrink the queue");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= COUNT_W'(2)) |->
      ($signed(cell_entry[0].prio) >= $signed(cell_entry[1].prio)))
    else $error("front cells out of priority order");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/spq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_entry,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               lower,
  output logic               match
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // held entry is served after the new one
  assign lower = ctl.occupied && ($signed(entry_r.prio) < $signed(new_entry.prio));
  assign match = ctl.occupied && (entry_r.index == new_entry.index);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert_en) begin
      if (ctl.shift_in) begin
        entry_nxt = left_entry;
      end else if (lower || ctl.at_tail) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.pull) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire
